// ===== rtl/core/pucl_pkg.sv =====
// Package for the per-user connection limit table.
// Sizes, opcodes, controller states and the structs shared by the core modules.
// No dependencies.
`default_nettype none

package pucl_pkg;

  localparam int TABLE_SIZE = 64;
  localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
  localparam int PID_W      = 22;
  localparam int UID_W      = 32;
  localparam int CAP_W      = 16;
  localparam int OUT_CNT_W  = 7;
  localparam int OP_W       = 2;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [PID_W-1:0]     pid_t;
  typedef logic [UID_W-1:0]     uid_t;
  typedef logic [CAP_W-1:0]     cap_t;
  typedef logic [OUT_CNT_W-1:0] out_cnt_t;

  localparam idx_t LAST_IDX  = idx_t'(TABLE_SIZE - 1);
  localparam cnt_t FULL_CNT  = cnt_t'(TABLE_SIZE);
  localparam cap_t CAP_RESET = cap_t'(8);
  localparam cap_t CAP_NONE  = '0;
  localparam pid_t FREE_PID  = '0;

  typedef enum logic [OP_W-1:0] {
    OP_QUERY  = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    pid_t pid;
    uid_t uid;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic clear;
    logic set;
    idx_t set_idx;
    logic drop;
    idx_t drop_idx;
  } occ_cmd_t;

  typedef struct packed {
    logic has_free;
    idx_t free_idx;
    cnt_t count;
    logic full;
  } occ_stat_t;

  typedef struct packed {
    logic     allowed;
    out_cnt_t user_count;
    logic     add_failed;
    out_cnt_t slots_in_use;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/pucl_if.sv =====
// Request and response channel interfaces for the connection limit table.
// Depends on pucl_pkg.
`default_nettype none

interface pucl_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  pucl_pkg::pid_t    process_id;
  pucl_pkg::uid_t    user_id;

  modport source (output valid, output opcode, output process_id, output user_id,
                  input ready);
  modport sink   (input valid, input opcode, input process_id, input user_id,
                  output ready);
endinterface

interface pucl_rsp_if;
  logic                valid;
  logic                ready;
  logic                allowed;
  pucl_pkg::out_cnt_t  user_count;
  logic                add_failed;
  pucl_pkg::out_cnt_t  slots_in_use;

  modport source (output valid, output allowed, output user_count, output add_failed,
                  output slots_in_use, input ready);
  modport sink   (input valid, input allowed, input user_count, input add_failed,
                  input slots_in_use, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pucl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pucl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/pucl_occ.sv =====
// Slot occupancy flags, first-free slot search and occupied slot count.
// Depends on pucl_pkg.
`default_nettype none

module pucl_occ (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire pucl_pkg::occ_cmd_t  cmd,
  input  wire pucl_pkg::idx_t      rd_idx,
  output logic                     rd_bit,
  output pucl_pkg::occ_stat_t      stat
);
  logic [pucl_pkg::TABLE_SIZE-1:0] occ;
  pucl_pkg::cnt_t                  count;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      occ   <= '0;
      count <= '0;
    end else begin
      if (cmd.set) begin
        occ[cmd.set_idx] <= 1'b1;
        count            <= count + pucl_pkg::cnt_t'(1);
      end else if (cmd.drop) begin
        occ[cmd.drop_idx] <= 1'b0;
        count             <= count - pucl_pkg::cnt_t'(1);
      end
    end
  end

  always_comb begin
    stat.free_idx = '0;
    for (int i = pucl_pkg::TABLE_SIZE - 1; i >= 0; i--) begin
      if (!occ[i]) begin
        stat.free_idx = pucl_pkg::idx_t'(i);
      end
    end
    stat.has_free = ~&occ;
    stat.count    = count;
    stat.full     = (count >= pucl_pkg::FULL_CNT);
    rd_bit        = occ[rd_idx];
  end

endmodule

`default_nettype wire

// ===== rtl/core/pucl_ctrl.sv =====
// Operation sequencer: accepts an item, writes adds, scans the slot RAM
// to count the user and free a process (not on clear), then presents the result.
// Depends on pucl_pkg.
`default_nettype none

module pucl_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_opcode,
  input  wire pucl_pkg::pid_t       in_pid,
  input  wire pucl_pkg::uid_t       in_uid,
  input  wire pucl_pkg::cap_t       cap,
  output logic                      res_valid,
  input  wire logic                 res_take,
  output pucl_pkg::result_t         res,
  output logic                      ram_we,
  output pucl_pkg::idx_t            ram_waddr,
  output pucl_pkg::entry_t          ram_wdata,
  output pucl_pkg::idx_t            ram_raddr,
  input  wire pucl_pkg::entry_t     ram_rdata,
  output pucl_pkg::occ_cmd_t        occ_cmd,
  output pucl_pkg::idx_t            occ_rd_idx,
  input  wire logic                 occ_rd_bit,
  input  wire pucl_pkg::occ_stat_t  occ_stat
);
  pucl_pkg::ctrl_state_t state, state_next;
  pucl_pkg::op_t         op;
  pucl_pkg::op_t         in_op;
  pucl_pkg::pid_t        pid;
  pucl_pkg::uid_t        uid;
  pucl_pkg::idx_t        addr;
  logic                  issuing;
  logic                  d_valid;
  pucl_pkg::idx_t        d_idx;
  pucl_pkg::cnt_t        ucount;
  logic                  removed;
  logic                  failed;
  logic                  accept;
  logic                  add_try;
  logic                  hit_u;
  logic                  hit_p;

  always_comb begin
    in_op      = pucl_pkg::op_t'(in_opcode);
    accept     = (state == pucl_pkg::ST_IDLE) && in_valid;
    add_try    = (in_op == pucl_pkg::OP_ADD) && (cap != pucl_pkg::CAP_NONE) &&
                 (in_pid != pucl_pkg::FREE_PID);
    hit_u      = d_valid && occ_rd_bit && (ram_rdata.uid == uid);
    hit_p      = d_valid && occ_rd_bit && (op == pucl_pkg::OP_REMOVE) &&
                 (pid != pucl_pkg::FREE_PID) && !removed && (ram_rdata.pid == pid);

    state_next = state;
    in_ready   = (state == pucl_pkg::ST_IDLE);
    res_valid  = (state == pucl_pkg::ST_DONE);
    ram_we     = 1'b0;
    ram_waddr  = occ_stat.free_idx;
    ram_wdata  = '{pid: in_pid, uid: in_uid};
    ram_raddr  = addr;
    occ_rd_idx = d_idx;
    occ_cmd    = '0;
    occ_cmd.set_idx  = occ_stat.free_idx;
    occ_cmd.drop_idx = d_idx;

    case (state)
      pucl_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_op == pucl_pkg::OP_CLEAR) begin
            occ_cmd.clear = 1'b1;
            state_next    = pucl_pkg::ST_DONE;
          end else begin
            state_next = pucl_pkg::ST_SCAN;
          end
          if (add_try && occ_stat.has_free) begin
            ram_we      = 1'b1;
            occ_cmd.set = 1'b1;
          end
        end
      end
      pucl_pkg::ST_SCAN: begin
        occ_cmd.drop = hit_p;
        if (d_valid && (d_idx == pucl_pkg::LAST_IDX)) begin
          state_next = pucl_pkg::ST_DONE;
        end
      end
      pucl_pkg::ST_DONE: begin
        if (res_take) begin
          state_next = pucl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pucl_pkg::ST_IDLE;
      end
    endcase

    res.allowed      = (op == pucl_pkg::OP_QUERY) &&
                       ((cap == pucl_pkg::CAP_NONE) || occ_stat.full ||
                        (pucl_pkg::cap_t'(ucount) < cap));
    res.user_count   = pucl_pkg::out_cnt_t'(ucount);
    res.add_failed   = failed;
    res.slots_in_use = pucl_pkg::out_cnt_t'(occ_stat.count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= pucl_pkg::ST_IDLE;
      issuing <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        issuing <= (in_op != pucl_pkg::OP_CLEAR);
        d_valid <= 1'b0;
      end else if (state == pucl_pkg::ST_SCAN) begin
        d_valid <= issuing;
        if (issuing && (addr == pucl_pkg::LAST_IDX)) begin
          issuing <= 1'b0;
        end
      end else begin
        issuing <= 1'b0;
        d_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= in_op;
      pid     <= in_pid;
      uid     <= in_uid;
      addr    <= '0;
      ucount  <= '0;
      removed <= 1'b0;
      failed  <= add_try && !occ_stat.has_free;
    end else if (state == pucl_pkg::ST_SCAN) begin
      if (issuing) begin
        addr <= addr + pucl_pkg::idx_t'(1);
      end
      d_idx <= addr;
      if (hit_p) begin
        removed <= 1'b1;
      end else if (hit_u) begin
        ucount <= ucount + pucl_pkg::cnt_t'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/per_user_connection_limit_table.sv =====
// Per-user connection limit table, top level.
// Query, add and remove scan every slot, one read per slot through the RAM's single
// read port; clear skips the scan. A new item is accepted only once the previous
// result has been taken into the output register.
// Reset: synchronous; cap returns to 8, all slots read as free, no clearing pass.
// Depends on pucl_pkg, pucl_if, pucl_ram, pucl_occ and pucl_ctrl.
`default_nettype none

module per_user_connection_limit_table (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire pucl_pkg::cap_t       cfg_wr_data,
  pucl_req_if.sink                  req,
  pucl_rsp_if.source                rsp
);
  pucl_pkg::cap_t      max_per_user;
  logic                res_valid;
  logic                res_take;
  pucl_pkg::result_t   res;
  logic                ram_we;
  pucl_pkg::idx_t      ram_waddr;
  pucl_pkg::entry_t    ram_wdata;
  pucl_pkg::idx_t      ram_raddr;
  pucl_pkg::entry_t    ram_rdata;
  pucl_pkg::occ_cmd_t  occ_cmd;
  pucl_pkg::idx_t      occ_rd_idx;
  logic                occ_rd_bit;
  pucl_pkg::occ_stat_t occ_stat;
  logic                out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_per_user <= pucl_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      max_per_user <= cfg_wr_data;
    end
  end

  pucl_ram #(
    .WIDTH (pucl_pkg::ENTRY_W),
    .DEPTH (pucl_pkg::TABLE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pucl_occ u_occ (
    .clk    (clk),
    .rst    (rst),
    .cmd    (occ_cmd),
    .rd_idx (occ_rd_idx),
    .rd_bit (occ_rd_bit),
    .stat   (occ_stat)
  );

  pucl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .in_opcode  (req.opcode),
    .in_pid     (req.process_id),
    .in_uid     (req.user_id),
    .cap        (max_per_user),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .occ_cmd    (occ_cmd),
    .occ_rd_idx (occ_rd_idx),
    .occ_rd_bit (occ_rd_bit),
    .occ_stat   (occ_stat)
  );

  assign res_take = res_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp.allowed      <= res.allowed;
      rsp.user_count   <= res.user_count;
      rsp.add_failed   <= res.add_failed;
      rsp.slots_in_use <= res.slots_in_use;
    end
  end

  assign rsp.valid = out_valid;

endmodule

`default_nettype wire
